FILE: sv/imm_pkg.sv
package imm_pkg;
    localparam int MaxIntervals = 64;
    localparam int IdxW = $clog2(MaxIntervals);
    localparam int CntW = $clog2(MaxIntervals + 1);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_MARK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] sample;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_RD,
        S_SORT_PRV,
        S_SORT_CMP,
        S_MERGE_RD,
        S_MERGE_ST,
        S_MERGE_FL,
        S_MARK_RD,
        S_MARK_CHK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        hit;
        logic [6:0]  merged_number;
        logic [31:0] merged_left;
        logic [31:0] merged_right;
        logic [3:0]  merged_type;
        logic        load_overflow;
        logic [6:0]  merged_count;
    } t_res;
endpackage

FILE: sv/interval_merge_and_mark_unit.sv
// Interval merge and mark unit. Operation 0 loads an interval (up to 64),
// 1 sorts and merges them, 2 marks a non-decreasing sample index. Each
// transaction yields one result. A load or an unused operation goes
// straight from idle to the output state; a build sorts the loaded entries
// by insertion sort, shifting one entry per step, then merges them in a
// single pass; a mark steps past each merged interval that ends at or before
// the sample. The engine holds one result and takes the next transaction
// only once that result is accepted; a two-entry input queue accepts
// transactions while the engine works.
module interval_merge_and_mark_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] operation, [33:2] interval_left, [65:34] interval_right,
    // [97:66] sample_index, zero fill to 104
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] hit, [7:1] merged_number, [39:8] merged_left, [71:40] merged_right,
    // [75:72] merged_type, [76] load_overflow, [83:77] merged_count, fill to 88
    output logic [87:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata
);
    import imm_pkg::*;

    t_cmd in_cmd, q_cmd;
    t_res res;
    logic q_valid, q_ready;
    logic [3:0] r_type;

    assign in_cmd.op     = t_op'(s_axis_tdata[1:0]);
    assign in_cmd.left   = s_axis_tdata[33:2];
    assign in_cmd.right  = s_axis_tdata[65:34];
    assign in_cmd.sample = s_axis_tdata[97:66];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_type <= '0;
        else if (i_cfg_we) r_type <= i_cfg_wdata;
    end

    imm_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    imm_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd), .i_type(r_type),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {4'd0, res.merged_count, res.load_overflow, res.merged_type,
                           res.merged_right, res.merged_left, res.merged_number, res.hit};
endmodule

FILE: sv/imm_front.sv
module imm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  imm_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output imm_pkg::t_cmd o_cmd
);
    import imm_pkg::*;

    // two-entry command queue between the port and the engine
    t_cmd       r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_cmd;
    end
endmodule

FILE: sv/imm_back.sv
module imm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  imm_pkg::t_cmd i_cmd,
    input  logic [3:0]    i_type,
    output logic          o_valid,
    input  logic          i_ready,
    output imm_pkg::t_res o_res
);
    import imm_pkg::*;

    logic [63:0] r_raw [MaxIntervals];
    logic [63:0] r_srt [MaxIntervals];
    logic [63:0] r_mrg [MaxIntervals];

    t_state      r_st, n_st;
    t_cmd        r_cmd;
    logic [CntW-1:0] r_raw_cnt, r_tot, r_cur, r_i, r_j, r_out;
    logic [63:0] r_key, r_rd, r_prev;
    logic [31:0] r_ms, r_me;
    t_res        r_res;
    logic        r_ov;

    logic take;
    logic ld_full;
    assign take    = i_valid && o_ready;
    assign ld_full = (r_raw_cnt == CntW'(MaxIntervals));
    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    logic [31:0] sm;
    assign sm = r_cmd.sample;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (take) begin
                    case (i_cmd.op)
                        OP_BUILD: n_st = S_SORT_RD;
                        OP_MARK:  n_st = S_MARK_RD;
                        default:  n_st = S_OUT;
                    endcase
                end
            end
            // insertion sort: raw entry i copied in at j==i, shifted down
            S_SORT_RD:  n_st = (r_i >= r_raw_cnt) ?
                               ((r_raw_cnt == '0) ? S_OUT : S_MERGE_RD) : S_SORT_PRV;
            S_SORT_PRV: n_st = S_SORT_CMP;
            S_SORT_CMP: n_st = (r_j != '0 && r_prev > r_key) ? S_SORT_PRV : S_SORT_RD;
            S_MERGE_RD: n_st = S_MERGE_ST;
            S_MERGE_ST: n_st = (r_i >= r_raw_cnt) ? S_MERGE_FL : S_MERGE_RD;
            S_MERGE_FL: n_st = S_OUT;
            S_MARK_RD:  n_st = S_MARK_CHK;
            S_MARK_CHK: n_st = (r_cur < r_tot && r_rd[31:0] <= sm) ? S_MARK_RD : S_OUT;
            S_OUT:      n_st = S_IDLE;
            default:    n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_raw_cnt <= '0;
            r_tot     <= '0;
            r_cur     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (take) begin
                        r_cmd <= i_cmd;
                        r_i   <= '0;
                        r_res <= {1'b0, 7'd0, 32'd0, 32'd0, 4'd0,
                                  (i_cmd.op == OP_LOAD) && ld_full, 7'd0};
                        if (i_cmd.op == OP_LOAD && !ld_full) begin
                            r_raw[r_raw_cnt[IdxW-1:0]] <= {i_cmd.left, i_cmd.right};
                            r_raw_cnt <= r_raw_cnt + 1'b1;
                        end
                        if (i_cmd.op == OP_BUILD) begin
                            r_tot <= '0;
                            r_cur <= '0;
                        end
                    end
                end
                S_SORT_RD: begin
                    if (r_i < r_raw_cnt) begin
                        r_key <= r_raw[r_i[IdxW-1:0]];
                        r_j   <= r_i;
                    end else begin
                        r_i   <= '0;
                        r_out <= '0;
                    end
                end
                S_SORT_PRV: begin
                    if (r_j != '0) r_prev <= r_srt[r_j[IdxW-1:0] - 1'b1];
                end
                S_SORT_CMP: begin
                    if (r_j != '0 && r_prev > r_key) begin
                        r_srt[r_j[IdxW-1:0]] <= r_prev;
                        r_j <= r_j - 1'b1;
                    end else begin
                        r_srt[r_j[IdxW-1:0]] <= r_key;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_MERGE_RD: begin
                    r_rd <= r_srt[r_i[IdxW-1:0]];
                    r_i  <= r_i + 1'b1;
                end
                S_MERGE_ST: begin
                    if (r_i == CntW'(1)) begin
                        r_ms <= r_rd[63:32];
                        r_me <= r_rd[31:0];
                    end else if (r_rd[63:32] <= r_me) begin
                        if (r_rd[31:0] > r_me) r_me <= r_rd[31:0];
                    end else begin
                        r_mrg[r_out[IdxW-1:0]] <= {r_ms, r_me};
                        r_out <= r_out + 1'b1;
                        r_ms  <= r_rd[63:32];
                        r_me  <= r_rd[31:0];
                    end
                end
                // write out the running interval
                S_MERGE_FL: begin
                    r_mrg[r_out[IdxW-1:0]] <= {r_ms, r_me};
                    r_tot <= r_out + 1'b1;
                end
                S_MARK_RD: begin
                    if (r_cur < r_tot) r_rd <= r_mrg[r_cur[IdxW-1:0]];
                end
                S_MARK_CHK: begin
                    if (r_cur < r_tot && r_rd[31:0] <= sm) begin
                        r_cur <= r_cur + 1'b1;
                    end else if (r_cur < r_tot && sm >= r_rd[63:32]) begin
                        r_res.hit           <= 1'b1;
                        r_res.merged_number <= 7'(r_cur);
                        r_res.merged_left   <= r_rd[63:32];
                        r_res.merged_right  <= r_rd[31:0];
                        r_res.merged_type   <= i_type;
                    end
                end
                S_OUT: begin
                    r_res.merged_count <= 7'(r_tot);
                    r_ov <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: sv/imm_checker.sv
module imm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [87:0]  m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped while stalled");
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[75:1] == '0)
        else $error("miss with nonzero fields");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[76]))
        else $error("hit and overflow together");
    a_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[7:1] < m_axis_tdata[83:77])
        else $error("hit number beyond count");
endmodule

bind interval_merge_and_mark_unit imm_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import imm_pkg::*;

    // first member lands in the top bits, so hit ends up at bit 0
    typedef struct packed {
        logic [6:0]  count;
        logic        overflow;
        logic [3:0]  tag;
        logic [31:0] right;
        logic [31:0] left;
        logic [6:0]  number;
        logic        hit;
    } mark_res_t;

    // Behavioral copy of the interval store, merged list and cursor.
    class interval_scoreboard;
        logic [63:0] raw_q[$];
        logic [63:0] merged_q[$];
        int          cursor;
        logic [3:0]  tag;
        mark_res_t   pending_q[$];
        int          errors;

        function new();
            cursor = 0;
            tag = 0;
            errors = 0;
        endfunction

        function void rebuild();
            logic [63:0] sorted[$];
            logic [31:0] cur_l, cur_r;
            sorted = raw_q;
            sorted.sort();
            merged_q.delete();
            cursor = 0;
            if (sorted.size() == 0) return;
            cur_l = sorted[0][63:32];
            cur_r = sorted[0][31:0];
            for (int i = 1; i < sorted.size(); i++) begin
                if (sorted[i][63:32] <= cur_r) begin
                    if (sorted[i][31:0] > cur_r) cur_r = sorted[i][31:0];
                end else begin
                    merged_q.insert(merged_q.size(), {cur_l, cur_r});
                    cur_l = sorted[i][63:32];
                    cur_r = sorted[i][31:0];
                end
            end
            merged_q.insert(merged_q.size(), {cur_l, cur_r});
        endfunction

        function void note_cmd(t_op op, logic [31:0] l, logic [31:0] r, logic [31:0] s);
            mark_res_t e;
            e = '0;
            case (op)
                OP_LOAD: begin
                    if (raw_q.size() < MaxIntervals) raw_q.insert(raw_q.size(), {l, r});
                    else e.overflow = 1'b1;
                end
                OP_BUILD: rebuild();
                OP_MARK: begin
                    while (cursor < merged_q.size() && merged_q[cursor][31:0] <= s)
                        cursor++;
                    if (cursor < merged_q.size() && s >= merged_q[cursor][63:32]
                            && s < merged_q[cursor][31:0]) begin
                        e.hit = 1'b1;
                        e.number = cursor[6:0];
                        e.left = merged_q[cursor][63:32];
                        e.right = merged_q[cursor][31:0];
                        e.tag = tag;
                    end
                end
                default: ;
            endcase
            e.count = 7'(merged_q.size());
            pending_q.insert(pending_q.size(), e);
        endfunction

        function void check_result(mark_res_t a);
            mark_res_t e;
            if (pending_q.size() == 0) begin
                $error("unexpected result %h", a);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (a.hit !== e.hit) begin
                $error("hit exp %0h got %0h", e.hit, a.hit); errors++;
            end
            if (a.number !== e.number) begin
                $error("merged_number exp %0d got %0d", e.number, a.number); errors++;
            end
            if (a.left !== e.left) begin
                $error("merged_left exp %0h got %0h", e.left, a.left); errors++;
            end
            if (a.right !== e.right) begin
                $error("merged_right exp %0h got %0h", e.right, a.right); errors++;
            end
            if (a.tag !== e.tag) begin
                $error("merged_type exp %0d got %0d", e.tag, a.tag); errors++;
            end
            if (a.overflow !== e.overflow) begin
                $error("load_overflow exp %0d got %0d", e.overflow, a.overflow); errors++;
            end
            if (a.count !== e.count) begin
                $error("merged_count exp %0d got %0d", e.count, a.count); errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;   // op, left, right, sample from bit 0 up
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;   // hit, number, left, right, type, overflow, count
    logic         i_cfg_we;
    logic [3:0]   i_cfg_wdata;

    interval_scoreboard sb;
    int  long_stall;
    logic [31:0] sample_pos;

    interval_merge_and_mark_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Receiver: random stall pattern, with one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[83:0]);
            if (long_stall > 0) begin
                long_stall <= long_stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    // valid stays high after acceptance; the next send or an idle task follows
    task automatic send_cmd(t_op op, logic [31:0] l, logic [31:0] r, logic [31:0] s);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, s, r, l, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_cmd(op, l, r, s);
    endtask

    task automatic pause_cycles(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        pause_cycles(1);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_tag(logic [3:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.tag = v;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // One round: loads (some inverted), a build, then mostly rising marks with occasional random ops.
    task automatic run_round(int loads, int marks, logic [31:0] span, bit keep);
        logic [31:0] l, w;
        if (!keep) begin
            // fresh store is not possible without reset; content just keeps growing up to capacity
        end
        for (int i = 0; i < loads; i++) begin
            l = $urandom_range(0, span);
            w = $urandom_range(0, 30);
            if ($urandom_range(0, 15) == 0) send_cmd(OP_LOAD, l, l - w, $urandom);
            else send_cmd(OP_LOAD, l, l + w, $urandom);
            if ($urandom_range(0, 3) == 0) pause_cycles($urandom_range(1, 6));
        end
        send_cmd(OP_BUILD, $urandom, $urandom, $urandom);
        sample_pos = $urandom_range(0, 10);
        for (int i = 0; i < marks; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_cmd(t_op'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            else begin
                if ($urandom_range(0, 29) == 0) sample_pos = sample_pos - 5;
                else sample_pos = sample_pos + $urandom_range(0, span / 16 + 2);
                send_cmd(OP_MARK, $urandom, $urandom, sample_pos);
            end
            if ($urandom_range(0, 5) == 0) pause_cycles($urandom_range(1, 8));
        end
    endtask

    initial begin
        sb = new();
        long_stall = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        pause_cycles(2);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set, unused op, extremes, inverted interval
        send_cmd(OP_MARK, 0, 0, 32'd5);
        send_cmd(OP_BUILD, 0, 0, 0);
        send_cmd(OP_MARK, 0, 0, 32'd0);
        send_cmd(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();
        write_tag(4'hF);
        send_cmd(OP_LOAD, 32'd10, 32'd20, 0);
        send_cmd(OP_LOAD, 32'd15, 32'd30, 0);
        send_cmd(OP_LOAD, 32'd30, 32'd40, 0);
        send_cmd(OP_LOAD, 32'd50, 32'd45, 0);
        send_cmd(OP_LOAD, 32'd0, 32'd0, 0);
        send_cmd(OP_LOAD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0);
        send_cmd(OP_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, 0);
        send_cmd(OP_BUILD, 0, 0, 0);
        send_cmd(OP_MARK, 0, 0, 32'd9);
        send_cmd(OP_MARK, 0, 0, 32'd10);
        send_cmd(OP_MARK, 0, 0, 32'd39);
        send_cmd(OP_MARK, 0, 0, 32'd20);
        send_cmd(OP_MARK, 0, 0, 32'd47);
        send_cmd(OP_MARK, 0, 0, 32'hFFFF_FFFE);
        send_cmd(OP_MARK, 0, 0, 32'hFFFF_FFFF);
        send_cmd(OP_MARK, 0, 0, 32'hFFFF_FFFF);
        wait_drained();
        write_tag(4'h0);

        // fill to capacity, then overflow
        run_round(60, 30, 32'd3000, 1'b1);
        wait_drained();
        write_tag(4'h5);
        for (int i = 0; i < 4; i++) send_cmd(OP_LOAD, $urandom, $urandom, $urandom);
        send_cmd(OP_BUILD, 0, 0, 0);

        // long receiver hold-off while the sender keeps offering items
        long_stall = 200;
        for (int i = 0; i < 30; i++) send_cmd(OP_MARK, 0, 0, i * 100);
        wait_drained();

        // random phase: store stays full, so overflow and large builds dominate;
        // marks with random spread exercise skip, hit, miss and exhaustion
        for (int ph = 0; ph < 15; ph++) begin
            wait_drained();
            write_tag($urandom_range(0, 15));
            for (int k = 0; k < 6; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_cmd(t_op'($urandom_range(0, 3)), rand_word(), rand_word(),
                             rand_word());
                end else begin
                    run_round($urandom_range(0, 3), $urandom_range(10, 30),
                              32'd1 << $urandom_range(4, 31), 1'b1);
                end
            end
            if (ph % 4 == 3) wait_drained();
        end
        wait_drained();

        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
